### rtl/chacha20_header_xor_core_defines.svh
// assertion macros for the chacha20 header xor core
// used by the top level only, no other dependencies
`ifndef CHACHA20_HEADER_XOR_CORE_DEFINES_SVH
`define CHACHA20_HEADER_XOR_CORE_DEFINES_SVH

`ifndef SYNTH
`define CC20HX_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cc20hx assertion failed");
`define CC20HX_ASSERT_NR(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("cc20hx assertion failed");
`else
`define CC20HX_ASSERT(name, clk, rst_n, prop)
`define CC20HX_ASSERT_NR(name, clk, prop)
`endif

`endif

### rtl/cc20hx_pkg.sv
// shared types, constants and round functions of the chacha20 header xor core
// no dependencies
package cc20hx_pkg;

  localparam int unsigned WordW       = 64;
  localparam int unsigned HdrW        = 4 * WordW;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned NumDblRnds  = 10;
  localparam int unsigned RndCntW     = $clog2(NumDblRnds);

  localparam logic [31:0] Sigma0 = 32'h61707865;
  localparam logic [31:0] Sigma1 = 32'h3320646e;
  localparam logic [31:0] Sigma2 = 32'h79622d32;
  localparam logic [31:0] Sigma3 = 32'h6b206574;

  typedef enum logic [CfgIdxW-1:0] {
    RegKey0      = 3'd0,
    RegKey1      = 3'd1,
    RegKey2      = 3'd2,
    RegKey3      = 3'd3,
    RegNonceLow  = 3'd4,
    RegNonceHigh = 3'd5
  } cfg_reg_e;

  typedef logic [15:0][31:0] blk_t;
  typedef logic [3:0][31:0]  quad_t;

  typedef struct packed {
    logic load_hdr;
    logic init_work;
    logic round_en;
    logic final_en;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_block;
  } sts_t;

  function automatic logic [31:0] rotl(logic [31:0] x, int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // v[0..3] = a, b, c, d
  function automatic quad_t qround(quad_t v);
    logic [31:0] a, b, c, d;
    a = v[0];
    b = v[1];
    c = v[2];
    d = v[3];
    a = a + b; d = rotl(d ^ a, 16);
    c = c + d; b = rotl(b ^ c, 12);
    a = a + b; d = rotl(d ^ a, 8);
    c = c + d; b = rotl(b ^ c, 7);
    return {d, c, b, a};
  endfunction

  function automatic blk_t dround(blk_t s);
    blk_t  t;
    quad_t q;
    t = s;
    for (int i = 0; i < 4; i++) begin
      q = qround({t[12+i], t[8+i], t[4+i], t[i]});
      t[i]    = q[0];
      t[4+i]  = q[1];
      t[8+i]  = q[2];
      t[12+i] = q[3];
    end
    for (int i = 0; i < 4; i++) begin
      q = qround({t[12+((i+3)&3)], t[8+((i+2)&3)], t[4+((i+1)&3)], t[i]});
      t[i]              = q[0];
      t[4+((i+1)&3)]    = q[1];
      t[8+((i+2)&3)]    = q[2];
      t[12+((i+3)&3)]   = q[3];
    end
    return t;
  endfunction

endpackage

### rtl/cc20hx_ctrl.sv
// controller fsm of the chacha20 header xor core
// depends on cc20hx_pkg
module cc20hx_ctrl
  import cc20hx_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic cfg_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StRound = 4'b0010,
    StFinal = 4'b0100,
    StOut   = 4'b1000
  } state_e;

  localparam logic [RndCntW-1:0] RndLast = RndCntW'(NumDblRnds - 1);

  state_e             state_q, state_d;
  logic [RndCntW-1:0] rnd_q, rnd_d;
  logic               out_valid_q, out_valid_d;
  logic               accept;

  assign accept      = in_valid_i & (state_q == StIdle);
  assign in_ready_o  = (state_q == StIdle);
  // a pending header word goes first so a write never lands beside it
  assign cfg_ready_o = (state_q == StIdle) & ~in_valid_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_o.load_hdr = 1'b1;
          if (sts_i.need_block) begin
            cmd_o.init_work = 1'b1;
            rnd_d           = '0;
            state_d         = StRound;
          end else begin
            state_d = StOut;
          end
        end
      end
      StRound: begin
        cmd_o.round_en = 1'b1;
        if (rnd_q == RndLast) begin
          rnd_d   = '0;
          state_d = StFinal;
        end else begin
          rnd_d = rnd_q + 1'b1;
        end
      end
      StFinal: begin
        cmd_o.final_en = 1'b1;
        state_d        = StOut;
      end
      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/cc20hx_dp.sv
// datapath of the chacha20 header xor core: key registers, round state,
// keystream block and output register; depends on cc20hx_pkg
module cc20hx_dp
  import cc20hx_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [WordW-1:0]   cfg_data_i,
  input  logic [HdrW-1:0]    hdr_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  output logic [HdrW-1:0]    out_o
);

  logic [WordW-1:0] key0_q, key1_q, key2_q, key3_q, nonce_lo_q;
  logic [31:0]      nonce_hi_q;
  logic [31:0]      ctr_q, ctr_d;
  logic [1:0]       half_q, half_d;
  logic             restart;
  blk_t             init_blk, work_q, ks_q;
  logic [HdrW-1:0]  hdr_q, out_q, ks_half;
  blk_t             ks_sum;

  always_comb begin
    init_blk[0]  = Sigma0;
    init_blk[1]  = Sigma1;
    init_blk[2]  = Sigma2;
    init_blk[3]  = Sigma3;
    init_blk[4]  = key0_q[31:0];
    init_blk[5]  = key0_q[63:32];
    init_blk[6]  = key1_q[31:0];
    init_blk[7]  = key1_q[63:32];
    init_blk[8]  = key2_q[31:0];
    init_blk[9]  = key2_q[63:32];
    init_blk[10] = key3_q[31:0];
    init_blk[11] = key3_q[63:32];
    init_blk[12] = ctr_q;
    init_blk[13] = nonce_lo_q[31:0];
    init_blk[14] = nonce_lo_q[63:32];
    init_blk[15] = nonce_hi_q;
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      ks_sum[i] = work_q[i] + init_blk[i];
    end
  end

  always_comb begin
    restart = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegKey0, RegKey1, RegKey2, RegKey3, RegNonceLow, RegNonceHigh: restart = 1'b1;
        default: restart = 1'b0;
      endcase
    end
  end

  always_comb begin
    ctr_d  = ctr_q;
    half_d = half_q;
    if (restart) begin
      ctr_d  = '0;
      half_d = 2'd2;
    end else if (cmd_i.final_en) begin
      ctr_d  = ctr_q + 32'd1;
      half_d = 2'd0;
    end else if (cmd_i.load_out) begin
      half_d = half_q + 2'd1;
    end
  end

  assign sts_o.need_block = half_q[1];
  assign ks_half = half_q[0] ? ks_q[15:8] : ks_q[7:0];
  assign out_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q     <= '0;
      key1_q     <= '0;
      key2_q     <= '0;
      key3_q     <= '0;
      nonce_lo_q <= '0;
      nonce_hi_q <= '0;
      ctr_q      <= '0;
      half_q     <= 2'd2;
    end else begin
      ctr_q  <= ctr_d;
      half_q <= half_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegKey0:      key0_q     <= cfg_data_i;
          RegKey1:      key1_q     <= cfg_data_i;
          RegKey2:      key2_q     <= cfg_data_i;
          RegKey3:      key3_q     <= cfg_data_i;
          RegNonceLow:  nonce_lo_q <= cfg_data_i;
          RegNonceHigh: nonce_hi_q <= cfg_data_i[31:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_hdr) begin
      hdr_q <= hdr_i;
    end
    if (cmd_i.init_work) begin
      work_q <= init_blk;
    end else if (cmd_i.round_en) begin
      work_q <= dround(work_q);
    end
    if (cmd_i.final_en) begin
      ks_q <= ks_sum;
    end
    if (cmd_i.load_out) begin
      out_q <= hdr_q ^ ks_half;
    end
  end

endmodule

### rtl/chacha20_header_xor_core.sv
// a result comes from the stored half of the current keystream block while
// one half is unused; when a new block is needed the word waits for it
// (10 double rounds, one per cycle, then the feed-forward add)
// one word is taken at a time: the next is accepted once the output register is loaded
// reset clears key and nonce to zero, counter to 0 and marks no block yet;
// an accepted write to a key or nonce register sets counter and block mark the same way
`include "chacha20_header_xor_core_defines.svh"

module chacha20_header_xor_core
  import cc20hx_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [WordW-1:0]   cfg_data_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // header_word_0, header_word_1, header_word_2, header_word_3
  input  logic [HdrW-1:0]    s_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // out_word_0, out_word_1, out_word_2, out_word_3
  output logic [HdrW-1:0]    m_axis_tdata
);

  cmd_t cmd;
  sts_t sts;
  logic cfg_we;

  assign cfg_we = cfg_valid_i & cfg_ready_o;

  cc20hx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cfg_ready_o (cfg_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cc20hx_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .hdr_i       (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_o       (m_axis_tdata)
  );

  `CC20HX_ASSERT(a_no_overwrite, clk_i, rst_ni, cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
  `CC20HX_ASSERT(a_valid_from_load, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(cmd.load_out))
  `CC20HX_ASSERT_NR(a_cmd_onehot, clk_i, $onehot0({cmd.init_work, cmd.round_en, cmd.final_en, cmd.load_out}))

endmodule
